[rtl/core/gdp_pkg.sv]
// Shared types, codes and the element length table of the generic data parser.
package gdp_pkg;

  localparam int unsigned OutDataW = 40;

  localparam logic [3:0] K_INF    = 4'd0;
  localparam logic [3:0] K_RII    = 4'd1;
  localparam logic [3:0] K_NGD    = 4'd2;
  localparam logic [3:0] K_GROUP  = 4'd3;
  localparam logic [3:0] K_ENTRY  = 4'd4;
  localparam logic [3:0] K_KOD    = 4'd5;
  localparam logic [3:0] K_TYPE   = 4'd6;
  localparam logic [3:0] K_WIDTH  = 4'd7;
  localparam logic [3:0] K_NUMBER = 4'd8;
  localparam logic [3:0] K_ELEM   = 4'd9;
  localparam logic [3:0] K_TRAIL  = 4'd10;
  localparam logic [3:0] K_ERR    = 4'd11;

  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_WIDTH   = 3'd3;
  localparam logic [2:0] ST_TRUNC   = 3'd4;

  localparam logic [5:0] SetMask  = 6'h3f;
  localparam logic [6:0] NumMask  = 7'h7f;
  localparam logic [7:0] TypeBits = 8'd2;

  typedef enum logic [11:0] {
    PH_INF    = 12'b0000_0000_0001,
    PH_RII    = 12'b0000_0000_0010,
    PH_NGD    = 12'b0000_0000_0100,
    PH_GROUP  = 12'b0000_0000_1000,
    PH_ENTRY  = 12'b0000_0001_0000,
    PH_KOD    = 12'b0000_0010_0000,
    PH_TYPE   = 12'b0000_0100_0000,
    PH_WIDTH  = 12'b0000_1000_0000,
    PH_NUMBER = 12'b0001_0000_0000,
    PH_ELEM   = 12'b0010_0000_0000,
    PH_TRAIL  = 12'b0100_0000_0000,
    PH_ERR    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [5:0]  set_index;
    logic [11:0] element_index;
    logic [7:0]  byte_index;
    logic        element_end;
    logic [2:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0] length;
    logic [2:0] err;
  } type_info_t;

  function automatic type_info_t type_length(logic [7:0] t, logic [7:0] w);
    type_info_t ti;
    ti.err    = ST_BUSY;
    ti.length = 8'd0;
    case (t)
      8'd1, 8'd3, 8'd4: ti.length = w;
      8'd2, 8'd9, 8'd10, 8'd11: ti.length = 8'd1;
      8'd7: begin
        ti.length = 8'd4;
        if (w != 8'd4) ti.err = ST_WIDTH;
      end
      8'd12: begin
        ti.length = 8'd2;
        if (w != 8'd2) ti.err = ST_WIDTH;
      end
      8'd18: begin
        ti.length = 8'd6;
        if (w != 8'd6) ti.err = ST_WIDTH;
      end
      8'd19: ti.length = 8'd10;
      8'd201: ti.length = 8'd5;
      default: ti.err = ST_UNKNOWN;
    endcase
    return ti;
  endfunction

endpackage

[rtl/core/iec103_generic_data_parser.sv]
// Top level of the generic data parser: input register, parse core and result register.
//
// The input channel carries one byte of a generic-data information body per request,
// with in_tlast set on the last byte of the body. For every accepted request the block
// returns exactly one result request on the output channel that tags the byte with its
// role (INF, RII, NGD, set header fields, element bytes, trailing or ignored after an
// error), its set, element and byte position, and a status. out_tlast echoes in_tlast,
// and the status of that final result tells whether the body ended legally.
// A request is taken into an input register and tagged by the parse core on the way to the
// result register; with the result register free, the tagged result moves from the input
// register into the result register and is shown on the output from there.
// One byte per cycle is taken while out_tready is high; the state updates once per byte.
// Reset empties both registers and returns the parser to expecting an INF byte; the
// parser also returns to that state after every byte marked with in_tlast.
// When the receiver holds out_tready low, the result register keeps its request, the
// input register fills, and in_tready falls until the result is taken.
module iec103_generic_data_parser
  import gdp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte
  input  logic                in_tlast,   // end_of_body
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // field_kind, set_index, element_index,
                                          // byte_index, element_end, status, zero fill
  output logic                out_tlast   // last
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res;
  logic       move;

  assign move      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  gdp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (move),
    .data_byte   (in_byte_r),
    .end_of_body (in_last_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.status, out_res_r.element_end, out_res_r.byte_index,
                       out_res_r.element_index, out_res_r.set_index, out_res_r.field_kind};
  assign out_tlast  = out_res_r.last;

endmodule

[rtl/core/gdp_core.sv]
// Parse state registers and the per-byte tagging logic of the generic data parser.
module gdp_core
  import gdp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] data_byte,
  input  logic       end_of_body,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [5:0]  sets_total_r, sets_total_nxt;
  logic [5:0]  set_count_r, set_count_nxt;
  logic [7:0]  gdd_type_r, gdd_type_nxt;
  logic [7:0]  gdd_width_r, gdd_width_nxt;
  logic [11:0] elements_total_r, elements_total_nxt;
  logic [11:0] element_count_r, element_count_nxt;
  logic [7:0]  element_length_r, element_length_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [2:0]  error_code_r, error_code_nxt;

  type_info_t  ti;
  logic [6:0]  num;
  logic [14:0] bits;
  logic [14:0] bits_up;
  logic [11:0] n_elems;
  logic [5:0]  set_inc;
  logic [7:0]  byte_inc;
  logic [11:0] elem_inc;
  logic        legal;
  logic [2:0]  status;

  assign ti       = type_length(gdd_type_r, gdd_width_r);
  assign num      = data_byte[6:0] & NumMask;
  assign bits     = {7'd0, gdd_width_r} * {8'd0, num};
  assign bits_up  = bits + 15'd7;
  assign set_inc  = (set_count_r + 6'd1) & SetMask;
  assign byte_inc = byte_count_r + 8'd1;
  assign elem_inc = element_count_r + 12'd1;

  always_comb begin
    if (gdd_type_r == TypeBits) begin
      if (bits == 15'd0) n_elems = 12'd1;
      else n_elems = bits_up[14:3];
    end else begin
      n_elems = {5'd0, num};
    end
  end

  always_comb begin
    phase_nxt          = phase_r;
    sets_total_nxt     = sets_total_r;
    set_count_nxt      = set_count_r;
    gdd_type_nxt       = gdd_type_r;
    gdd_width_nxt      = gdd_width_r;
    elements_total_nxt = elements_total_r;
    element_count_nxt  = element_count_r;
    element_length_nxt = element_length_r;
    byte_count_nxt     = byte_count_r;
    error_code_nxt     = error_code_r;
    res                = '0;
    status             = ST_BUSY;
    legal              = 1'b0;

    unique case (phase_r)
      PH_INF: begin
        res.field_kind = K_INF;
        phase_nxt      = PH_RII;
      end
      PH_RII: begin
        res.field_kind = K_RII;
        legal          = 1'b1;
        phase_nxt      = PH_NGD;
      end
      PH_NGD: begin
        res.field_kind = K_NGD;
        sets_total_nxt = data_byte[5:0] & SetMask;
        set_count_nxt  = 6'd0;
        if (data_byte[5:0] == 6'd0) begin
          phase_nxt = PH_TRAIL;
          legal     = 1'b1;
        end else begin
          phase_nxt = PH_GROUP;
        end
      end
      PH_GROUP: begin
        res.field_kind = K_GROUP;
        res.set_index  = set_count_r;
        phase_nxt      = PH_ENTRY;
      end
      PH_ENTRY: begin
        res.field_kind = K_ENTRY;
        res.set_index  = set_count_r;
        phase_nxt      = PH_KOD;
      end
      PH_KOD: begin
        res.field_kind = K_KOD;
        res.set_index  = set_count_r;
        legal          = 1'b1;
        phase_nxt      = PH_TYPE;
      end
      PH_TYPE: begin
        res.field_kind = K_TYPE;
        res.set_index  = set_count_r;
        gdd_type_nxt   = data_byte;
        phase_nxt      = PH_WIDTH;
      end
      PH_WIDTH: begin
        res.field_kind = K_WIDTH;
        res.set_index  = set_count_r;
        gdd_width_nxt  = data_byte;
        phase_nxt      = PH_NUMBER;
      end
      PH_NUMBER: begin
        res.field_kind     = K_NUMBER;
        res.set_index      = set_count_r;
        element_length_nxt = ti.length;
        elements_total_nxt = n_elems;
        element_count_nxt  = 12'd0;
        byte_count_nxt     = 8'd0;
        if (n_elems != 12'd0 && ti.err != ST_BUSY) begin
          error_code_nxt = ti.err;
          status         = ti.err;
          phase_nxt      = PH_ERR;
        end else if (n_elems == 12'd0 || ti.length == 8'd0) begin
          set_count_nxt = set_inc;
          if (set_inc == sets_total_r) begin
            phase_nxt = PH_TRAIL;
            legal     = 1'b1;
          end else begin
            phase_nxt = PH_GROUP;
          end
        end else begin
          phase_nxt = PH_ELEM;
        end
      end
      PH_ELEM: begin
        res.field_kind    = K_ELEM;
        res.set_index     = set_count_r;
        res.element_index = element_count_r;
        res.byte_index    = byte_count_r;
        byte_count_nxt    = byte_inc;
        if (byte_inc == element_length_r) begin
          res.element_end   = 1'b1;
          byte_count_nxt    = 8'd0;
          element_count_nxt = elem_inc;
          if (elem_inc == elements_total_r) begin
            set_count_nxt = set_inc;
            if (set_inc == sets_total_r) begin
              phase_nxt = PH_TRAIL;
              legal     = 1'b1;
            end else begin
              phase_nxt = PH_GROUP;
            end
          end
        end
      end
      PH_TRAIL: begin
        res.field_kind = K_TRAIL;
        legal          = 1'b1;
      end
      PH_ERR: begin
        res.field_kind = K_ERR;
        status         = error_code_r;
      end
      default: begin
        res.field_kind = K_ERR;
        status         = error_code_r;
      end
    endcase

    if (end_of_body && status == ST_BUSY) begin
      status = legal ? ST_OK : ST_TRUNC;
    end
    res.status = status;
    res.last   = end_of_body;

    // The byte that closes a body returns every counter to its reset value.
    if (end_of_body) begin
      phase_nxt          = PH_INF;
      sets_total_nxt     = 6'd0;
      set_count_nxt      = 6'd0;
      gdd_type_nxt       = 8'd0;
      gdd_width_nxt      = 8'd0;
      elements_total_nxt = 12'd0;
      element_count_nxt  = 12'd0;
      element_length_nxt = 8'd0;
      byte_count_nxt     = 8'd0;
      error_code_nxt     = ST_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_INF;
      sets_total_r     <= 6'd0;
      set_count_r      <= 6'd0;
      gdd_type_r       <= 8'd0;
      gdd_width_r      <= 8'd0;
      elements_total_r <= 12'd0;
      element_count_r  <= 12'd0;
      element_length_r <= 8'd0;
      byte_count_r     <= 8'd0;
      error_code_r     <= ST_BUSY;
    end else if (step) begin
      phase_r          <= phase_nxt;
      sets_total_r     <= sets_total_nxt;
      set_count_r      <= set_count_nxt;
      gdd_type_r       <= gdd_type_nxt;
      gdd_width_r      <= gdd_width_nxt;
      elements_total_r <= elements_total_nxt;
      element_count_r  <= element_count_nxt;
      element_length_r <= element_length_nxt;
      byte_count_r     <= byte_count_nxt;
      error_code_r     <= error_code_nxt;
    end
  end

endmodule
